/* rtl/tkti_pkg.sv */
// Shared types and constants for the best-time insertion tables.
`default_nettype none

package tkti_pkg;

    localparam int unsigned TIME_W  = 24;
    localparam int unsigned DAY_W   = 24;
    localparam int unsigned CAT_IN_W = 2;
    localparam int unsigned RANK_W  = 3;
    localparam int unsigned COUNT_W = 4;

    // One input beat
    typedef struct packed {
        logic [CAT_IN_W-1:0] category;
        logic [TIME_W-1:0]   time_value;
        logic [DAY_W-1:0]    day_number;
    } in_beat_t;

    // One result beat
    typedef struct packed {
        logic               accepted;
        logic [RANK_W-1:0]  rank;
        logic [TIME_W-1:0]  best_time;
        logic [COUNT_W-1:0] entry_count;
    } out_beat_t;

    // Hand-off from one cell to the next one down the row
    typedef struct packed {
        logic              ins;
        logic [TIME_W-1:0] time_v;
        logic [DAY_W-1:0]  day_v;
    } cell_link_t;

endpackage

`default_nettype wire

/* rtl/tkti_stream_if.sv */
// Valid/ready stream channel carrying one payload beat.
`default_nettype none

interface tkti_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/tkti_cell.sv */
// One table slot for every category: compares, inserts or takes its neighbour's entry.
`default_nettype none

module tkti_cell #(
    parameter int unsigned CATEGORY_COUNT = 4,
    parameter int unsigned CAT_W          = 2
) (
    input  wire logic                        clk,
    input  wire logic [CAT_W-1:0]            cat_idx,
    input  wire logic                        slot_valid,
    input  wire logic                        wr_en,
    input  wire logic [tkti_pkg::TIME_W-1:0] new_time,
    input  wire logic [tkti_pkg::DAY_W-1:0]  new_day,
    input  wire tkti_pkg::cell_link_t        link_in,
    output tkti_pkg::cell_link_t             link_out
);

    logic [tkti_pkg::TIME_W-1:0] time_reg [CATEGORY_COUNT];
    logic [tkti_pkg::DAY_W-1:0]  day_reg  [CATEGORY_COUNT];

    logic [tkti_pkg::TIME_W-1:0] cur_time;
    logic [tkti_pkg::DAY_W-1:0]  cur_day;
    logic                        ins;
    logic [tkti_pkg::TIME_W-1:0] time_next;
    logic [tkti_pkg::DAY_W-1:0]  day_next;

    // Slot is at or after the insertion point: empty, or holding a slower time
    always_comb
    begin
        cur_time = time_reg[cat_idx];
        cur_day  = day_reg[cat_idx];
        ins      = !slot_valid || (cur_time > new_time);
        // Take the neighbour's entry past the insertion point, the new one at it
        time_next = link_in.ins ? link_in.time_v : new_time;
        day_next  = link_in.ins ? link_in.day_v  : new_day;
    end

    assign link_out = '{ins: ins, time_v: cur_time, day_v: cur_day};

    // Load the selected category's slot
    always_ff @(posedge clk)
    begin
        if (wr_en && ins)
        begin
            time_reg[cat_idx] <= time_next;
            day_reg[cat_idx]  <= day_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/top_k_time_table_insert_top.sv */
// Top level of the best-time insertion tables: cell row, fill counts and result register.
`default_nettype none

// Keeps an ascending table of up to TABLE_DEPTH (time, day) entries for each of
// CATEGORY_COUNT categories. Each input beat offers one entry to one table; it is
// placed after every entry with an equal or smaller time, so ties keep arrival
// order, and the slowest entry drops off a full table. A row of TABLE_DEPTH cells,
// one per slot, compares every slot against the new time at once and shifts the
// row together, so one beat is taken per clock and its result is held in the output
// register from the next cycle. A new beat is taken while the previous result is
// being taken; the row stalls only while an unread result is held. A category
// number at or beyond CATEGORY_COUNT changes nothing and yields an all-zero result.
// All tables are empty after reset; no clearing pass is needed.
module top_k_time_table_insert_top #(
    parameter int unsigned TABLE_DEPTH    = 8,
    parameter int unsigned CATEGORY_COUNT = 4
) (
    input wire logic  clk,
    input wire logic  rst_n,
    tkti_stream_if.sink   in_ch,
    tkti_stream_if.source out_ch
);

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned POS_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CAT_W = (CATEGORY_COUNT > 1) ? $clog2(CATEGORY_COUNT) : 1;

    logic [CNT_W-1:0]         fill_reg  [CATEGORY_COUNT];
    logic                     out_valid_reg;
    logic                     out_valid_next;
    tkti_pkg::out_beat_t      result_reg;
    tkti_pkg::out_beat_t      result_next;

    tkti_pkg::in_beat_t       beat;
    tkti_pkg::cell_link_t     link [TABLE_DEPTH+1];
    logic                     in_fire;
    logic                     cat_ok;
    logic [CAT_W-1:0]         cat_idx;
    logic [CNT_W-1:0]         cur_count;
    logic [CNT_W-1:0]         new_count;
    logic                     wr_en;
    logic                     place;
    logic [POS_W-1:0]         pos;

    assign beat      = in_ch.payload;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign cat_ok    = (32'(beat.category) < CATEGORY_COUNT);
    assign cat_idx   = CAT_W'(beat.category);
    assign cur_count = fill_reg[cat_idx];
    assign wr_en     = in_fire && cat_ok;

    // Head of the row: nothing moves into slot zero from above
    assign link[0] = '{ins: 1'b0, time_v: '0, day_v: '0};

    // Cell row, one cell per slot
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic slot_valid;
        assign slot_valid = (cur_count > CNT_W'(i));

        tkti_cell #(
            .CATEGORY_COUNT (CATEGORY_COUNT),
            .CAT_W          (CAT_W)
        ) u_cell (
            .clk        (clk),
            .cat_idx    (cat_idx),
            .slot_valid (slot_valid),
            .wr_en      (wr_en),
            .new_time   (beat.time_value),
            .new_day    (beat.day_number),
            .link_in    (link[i]),
            .link_out   (link[i+1])
        );
    end

    // Encode the insertion point and work out the new fill count
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (link[i+1].ins && !link[i].ins)
            begin
                pos = pos | POS_W'(i);
            end
        end
        place     = cat_ok && link[TABLE_DEPTH].ins;
        new_count = cur_count;
        if (place && (cur_count < CNT_W'(TABLE_DEPTH)))
        begin
            new_count = cur_count + CNT_W'(1);
        end
    end

    // Build the result beat
    always_comb
    begin
        result_next = '0;
        if (cat_ok)
        begin
            result_next.accepted    = place;
            result_next.rank        = place ? tkti_pkg::RANK_W'(pos) : '0;
            result_next.best_time   = link[1].ins ? beat.time_value : link[1].time_v;
            result_next.entry_count = tkti_pkg::COUNT_W'(new_count);
        end
    end

    // Hold the result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CATEGORY_COUNT; c++)
            begin
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (wr_en && place)
            begin
                fill_reg[cat_idx] <= new_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = result_reg;

    // A held result blocks new beats
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !in_ch.ready)
        else $error("input taken while a result is held");

    // An accepted entry leaves a non-empty table
    a_accept_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.accepted) |-> (result_reg.entry_count != '0))
        else $error("accepted entry with empty table");

    // Rejected entries report rank zero
    a_reject_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.accepted) |-> (result_reg.rank == '0))
        else $error("rejected entry with non-zero rank");

    // Fill count of the first table never exceeds the depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[0] <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // A beat always yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("no result after accepted beat");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the best-time insertion tables: directed table, then random inserts.
`timescale 1ns / 1ps

module tb_top;

    import tkti_pkg::*;

    localparam int unsigned DEPTH          = 8;
    localparam int unsigned CATS           = 4;
    localparam int unsigned TIME_MAX       = 24'hFFFFFF;
    localparam int unsigned DRIFT          = 64;
    localparam int unsigned BEATS_PER_PASS = 412;
    localparam int unsigned NUM_DIRECTED   = 23;
    localparam int unsigned CYCLE_LIMIT    = 400000;

    // One row of the directed table; the typed result is used only when has_result is set
    typedef struct {
        logic [CAT_IN_W-1:0] cat;
        logic [TIME_W-1:0]   t_val;
        logic [DAY_W-1:0]    d_val;
        bit                  has_result;
        logic                acc;
        logic [RANK_W-1:0]   rnk;
        logic [TIME_W-1:0]   best;
        logic [COUNT_W-1:0]  cnt;
    } directed_row_t;

    logic clk;
    logic rst_n;

    tkti_stream_if #(.payload_t(in_beat_t))  in_ch ();
    tkti_stream_if #(.payload_t(out_beat_t)) out_ch ();

    top_k_time_table_insert_top #(
        .TABLE_DEPTH    (DEPTH),
        .CATEGORY_COUNT (CATS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Own copy of the tables, kept in step with every accepted input beat
    logic [TIME_W-1:0]  best_times [CATS][DEPTH];
    logic [DAY_W-1:0]   best_days  [CATS][DEPTH];
    int unsigned        table_fill [CATS];

    out_beat_t          pending_results [$];
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        placed_seen;
    int unsigned        beats_sent;
    int unsigned        cycle_count;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // empty table: first entry lands at the top
        '{2'd0, 24'h000100, 24'h000000, 1'b1, 1'b1, 3'd0, 24'h000100, 4'd1},
        '{2'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 3'd1, 24'h000100, 4'd2},
        '{2'd0, 24'h000000, 24'h123456, 1'b1, 1'b1, 3'd0, 24'h000000, 4'd3},
        // equal time goes after the earlier one
        '{2'd0, 24'h000000, 24'h000001, 1'b1, 1'b1, 3'd1, 24'h000000, 4'd4},
        '{2'd0, 24'h000200, 24'h800000, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd0, 24'h000300, 24'h7FFFFF, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd0, 24'h000400, 24'h0AAAAA, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd0, 24'h000500, 24'h055555, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        // full table, tie with the slowest entry: turned away
        '{2'd0, 24'hFFFFFF, 24'h000002, 1'b1, 1'b0, 3'd0, 24'h000000, 4'd8},
        // full table, mid insert pushes the slowest off
        '{2'd0, 24'h000250, 24'h000003, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd1, 24'hFFFFFF, 24'hAAAAAA, 1'b1, 1'b1, 3'd0, 24'hFFFFFF, 4'd1},
        '{2'd2, 24'h555555, 24'h555555, 1'b1, 1'b1, 3'd0, 24'h555555, 4'd1},
        '{2'd3, 24'hAAAAAA, 24'hFFFFFF, 1'b1, 1'b1, 3'd0, 24'hAAAAAA, 4'd1},
        // fill one table with equal times
        '{2'd3, 24'hAAAAAA, 24'h000011, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd3, 24'hAAAAAA, 24'h000022, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd3, 24'hAAAAAA, 24'h000033, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd3, 24'hAAAAAA, 24'h000044, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd3, 24'hAAAAAA, 24'h000055, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd3, 24'hAAAAAA, 24'h000066, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd3, 24'hAAAAAA, 24'h000077, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd3, 24'hAAAAAA, 24'h000000, 1'b1, 1'b0, 3'd0, 24'hAAAAAA, 4'd8},
        '{2'd3, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0},
        '{2'd1, 24'h000001, 24'h000000, 1'b0, 1'b0, 3'd0, 24'h000000, 4'd0}
    };

    // Place one entry in the local tables and return the result it should give
    function automatic out_beat_t rank_entry(input in_beat_t beat);
        out_beat_t   res;
        int unsigned cat;
        int unsigned cnt;
        int unsigned pos;
        int unsigned last;
        bit          found;
        res   = '0;
        cat   = beat.category;
        found = 1'b0;
        if (cat >= CATS)
            return res;
        cnt = (table_fill[cat] > DEPTH) ? DEPTH : table_fill[cat];
        pos = cnt;
        // first slot holding a strictly slower time
        for (int unsigned i = 0; i < cnt; i++)
        begin
            if (!found && best_times[cat][i] > beat.time_value)
            begin
                pos   = i;
                found = 1'b1;
            end
        end
        if (pos < DEPTH)
        begin
            last = (cnt > DEPTH - 1) ? DEPTH - 1 : cnt;
            for (int unsigned i = last; i > pos; i--)
            begin
                best_times[cat][i] = best_times[cat][i-1];
                best_days[cat][i]  = best_days[cat][i-1];
            end
            best_times[cat][pos] = beat.time_value;
            best_days[cat][pos]  = beat.day_number;
            if (cnt < DEPTH)
                cnt++;
            table_fill[cat] = cnt;
            res.accepted    = 1'b1;
            res.rank        = RANK_W'(pos);
        end
        res.best_time   = (cnt != 0) ? best_times[cat][0] : '0;
        res.entry_count = COUNT_W'(cnt);
        return res;
    endfunction

    // Offer one beat, holding valid until it is taken, and log what it should produce
    task automatic send_beat(input in_beat_t beat, input bit has_result, input out_beat_t typed);
        out_beat_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= beat;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = rank_entry(beat);
        pending_results = {pending_results, (has_result ? typed : predicted)};
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Free-running clock
    always #1 clk = ~clk;

    // Receiver back-pressure, redrawn on every falling edge
    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        out_beat_t got;
        out_beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            results_seen++;
            if (got.accepted === 1'b1)
                placed_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing pending: %p", got);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
                compare_field("rank", 32'(want.rank), 32'(got.rank));
                compare_field("best_time", 32'(want.best_time), 32'(got.best_time));
                compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("top_k_time_table_insert_top regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        in_beat_t    beat;
        out_beat_t   typed;
        int unsigned cat;
        int unsigned cnt;
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        int unsigned best;
        int unsigned worst;
        int unsigned t;
        int unsigned idle_plan [4][2];

        idle_plan      = '{'{0, 0}, '{81, 0}, '{0, 81}, '{38, 38}};
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        results_seen   = 0;
        placed_seen    = 0;
        beats_sent     = 0;
        cycle_count    = 0;
        for (int unsigned c = 0; c < CATS; c++)
        begin
            table_fill[c] = 0;
            for (int unsigned s = 0; s < DEPTH; s++)
            begin
                best_times[c][s] = '0;
                best_days[c][s]  = '0;
            end
        end

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        foreach (directed_rows[i])
        begin
            beat.category      = directed_rows[i].cat;
            beat.time_value    = directed_rows[i].t_val;
            beat.day_number    = directed_rows[i].d_val;
            typed.accepted     = directed_rows[i].acc;
            typed.rank         = directed_rows[i].rnk;
            typed.best_time    = directed_rows[i].best;
            typed.entry_count  = directed_rows[i].cnt;
            send_beat(beat, directed_rows[i].has_result, typed);
        end

        // Random inserts, one pass per idling mix
        typed = '0;
        for (int unsigned p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_plan[p][0];
            recv_stall_pct = idle_plan[p][1];
            for (int unsigned n = 0; n < BEATS_PER_PASS; n++)
            begin
                cat  = $urandom_range(0, CATS - 1);
                cnt  = table_fill[cat];
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    t = $urandom_range(TIME_MAX, 0);
                else if (pick < 22)
                    t = TIME_MAX;
                else if (pick == 22)
                    t = 0;
                else if (pick < 45 && cnt != 0)
                    t = best_times[cat][$urandom_range(0, cnt - 1)];
                else
                begin
                    // aim just around the current table so most entries land somewhere
                    if (cnt == 0)
                    begin
                        lo = 0;
                        hi = TIME_MAX;
                    end
                    else
                    begin
                        best  = best_times[cat][0];
                        worst = best_times[cat][cnt-1];
                        lo    = (best > DRIFT) ? best - DRIFT : 0;
                        if (cnt == DEPTH)
                            hi = worst;
                        else
                            hi = (worst > TIME_MAX - DRIFT) ? TIME_MAX : worst + DRIFT;
                    end
                    t = $urandom_range(hi, lo);
                end
                beat.category   = CAT_IN_W'(cat);
                beat.time_value = TIME_W'(t);
                beat.day_number = DAY_W'($urandom);
                send_beat(beat, 1'b0, typed);
            end
        end
        in_ch.valid <= 1'b0;

        // Drain, then wait for any stray result beat
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d input beats over four idling mixes; checked %0d results.",
                 beats_sent, results_seen);
        $display("Entries placed: %0d, turned away: %0d, mismatches: %0d.",
                 placed_seen, results_seen - placed_seen, mismatches);
        if (mismatches == 0)
            $display("top_k_time_table_insert_top regression: pass");
        else
            $display("top_k_time_table_insert_top regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/tkti_pkg.sv
rtl/tkti_stream_if.sv
rtl/tkti_cell.sv
rtl/top_k_time_table_insert_top.sv
verif/tb_top.sv
